// ===== hdl/gr_pkg.sv =====
package gr_pkg;

    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_CELLS  = GLYPH_COLS * GLYPH_ROWS;
    localparam int FONT_ENTRIES = 95;

    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] LAST_CODE  = 8'h7E;

    localparam int DEF_SCALE_FACTOR = 3;
    localparam int DEF_FIFO_DEPTH   = 4;

    localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd160;
    localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd128;

    // configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic        big_scale;
        logic [15:0] color;
        logic [7:0]  char_code;
        logic [9:0]  pos_y;
        logic [9:0]  pos_x;
    } t_req;

    // five column bytes, column 0 in the top byte
    function automatic logic [39:0] font_cols(input logic [6:0] idx);
        logic [39:0] c;
        case (idx)
            7'd0:  c = 40'h0000000000;
            7'd1:  c = 40'h00005F0000;
            7'd2:  c = 40'h0007000700;
            7'd3:  c = 40'h147F147F14;
            7'd4:  c = 40'h242A7F2A12;
            7'd5:  c = 40'h2313086462;
            7'd6:  c = 40'h3649552250;
            7'd7:  c = 40'h0005030000;
            7'd8:  c = 40'h001C224100;
            7'd9:  c = 40'h0041221C00;
            7'd10: c = 40'h082A1C2A08;
            7'd11: c = 40'h08083E0808;
            7'd12: c = 40'h0050300000;
            7'd13: c = 40'h0808080808;
            7'd14: c = 40'h0060600000;
            7'd15: c = 40'h2010080402;
            7'd16: c = 40'h3E5149453E;
            7'd17: c = 40'h00427F4000;
            7'd18: c = 40'h4261514946;
            7'd19: c = 40'h2141454B31;
            7'd20: c = 40'h1814127F10;
            7'd21: c = 40'h2745454539;
            7'd22: c = 40'h3C4A494930;
            7'd23: c = 40'h0171090503;
            7'd24: c = 40'h3649494936;
            7'd25: c = 40'h064949291E;
            7'd26: c = 40'h0036360000;
            7'd27: c = 40'h0056360000;
            7'd28: c = 40'h0008142241;
            7'd29: c = 40'h1414141414;
            7'd30: c = 40'h4122140800;
            7'd31: c = 40'h0201510906;
            7'd32: c = 40'h324979413E;
            7'd33: c = 40'h7E1111117E;
            7'd34: c = 40'h7F49494936;
            7'd35: c = 40'h3E41414122;
            7'd36: c = 40'h7F4141221C;
            7'd37: c = 40'h7F49494941;
            7'd38: c = 40'h7F09090101;
            7'd39: c = 40'h3E41415132;
            7'd40: c = 40'h7F0808087F;
            7'd41: c = 40'h00417F4100;
            7'd42: c = 40'h2040413F01;
            7'd43: c = 40'h7F08142241;
            7'd44: c = 40'h7F40404040;
            7'd45: c = 40'h7F0204027F;
            7'd46: c = 40'h7F0408107F;
            7'd47: c = 40'h3E4141413E;
            7'd48: c = 40'h7F09090906;
            7'd49: c = 40'h3E4151215E;
            7'd50: c = 40'h7F09192946;
            7'd51: c = 40'h4649494931;
            7'd52: c = 40'h01017F0101;
            7'd53: c = 40'h3F4040403F;
            7'd54: c = 40'h1F2040201F;
            7'd55: c = 40'h7F2018207F;
            7'd56: c = 40'h6314081463;
            7'd57: c = 40'h0304780403;
            7'd58: c = 40'h6151494543;
            7'd59: c = 40'h00007F4141;
            7'd60: c = 40'h0204081020;
            7'd61: c = 40'h41417F0000;
            7'd62: c = 40'h0402010204;
            7'd63: c = 40'h4040404040;
            7'd64: c = 40'h0001020400;
            7'd65: c = 40'h2054545478;
            7'd66: c = 40'h7F48444438;
            7'd67: c = 40'h3844444420;
            7'd68: c = 40'h384444487F;
            7'd69: c = 40'h3854545418;
            7'd70: c = 40'h087E090102;
            7'd71: c = 40'h081454543C;
            7'd72: c = 40'h7F08040478;
            7'd73: c = 40'h00447D4000;
            7'd74: c = 40'h2040443D00;
            7'd75: c = 40'h007F102844;
            7'd76: c = 40'h00417F4000;
            7'd77: c = 40'h7C04180478;
            7'd78: c = 40'h7C08040478;
            7'd79: c = 40'h3844444438;
            7'd80: c = 40'h7C14141408;
            7'd81: c = 40'h081414187C;
            7'd82: c = 40'h7C08040408;
            7'd83: c = 40'h4854545420;
            7'd84: c = 40'h043F444020;
            7'd85: c = 40'h3C4040207C;
            7'd86: c = 40'h1C2040201C;
            7'd87: c = 40'h3C4030403C;
            7'd88: c = 40'h4428102844;
            7'd89: c = 40'h0C5050503C;
            7'd90: c = 40'h4464544C44;
            7'd91: c = 40'h0008364100;
            7'd92: c = 40'h00007F0000;
            7'd93: c = 40'h0041360800;
            7'd94: c = 40'h08082A1C08;
            default: c = 40'h0000000000;
        endcase
        return c;
    endfunction

    // 35 cell bits in scan order: bit col*7+row
    function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [7:0] code);
        logic [6:0]             idx;
        logic [39:0]            cols;
        logic [GLYPH_CELLS-1:0] b;
        if (code < FIRST_CODE || code > LAST_CODE) begin
            idx = 7'd0;
        end else begin
            idx = 7'(code - FIRST_CODE);
        end
        cols = font_cols(idx);
        for (int c = 0; c < GLYPH_COLS; c++) begin
            b[c*GLYPH_ROWS +: GLYPH_ROWS] = cols[(GLYPH_COLS-1-c)*8 +: GLYPH_ROWS];
        end
        return b;
    endfunction

endpackage

// ===== hdl/glyph_rasterizer.sv =====
// Requests queue in a RAM FIFO; the scanner walks the 35 font cells of the head at one
// cell per cycle while the output keeps up, plus a head load for each character.
// Each write is held until the next shows whether it is last. Reset (synchronous,
// active low) empties the FIFO and pipeline and loads the default screen size of 160 x 128.
module glyph_rasterizer
    import gr_pkg::*;
#(
    parameter int SCALE_FACTOR = DEF_SCALE_FACTOR,
    parameter int FIFO_DEPTH   = DEF_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // pos_x, pos_y, char_code, color, zero pad
    input  logic        i_s_tuser,   // big_scale
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // cell_x, cell_y, pixel_mask, pixel_color, zero pad
    output logic        o_m_tlast
);

    t_req        w_req, w_head;
    logic        w_full, w_empty, w_pop;
    logic [10:0] w_cell_x, w_cell_y;
    logic [8:0]  w_mask;
    logic [15:0] w_color;

    assign w_req.pos_x     = i_s_tdata[9:0];
    assign w_req.pos_y     = i_s_tdata[19:10];
    assign w_req.char_code = i_s_tdata[27:20];
    assign w_req.color     = i_s_tdata[43:28];
    assign w_req.big_scale = i_s_tuser;

    assign o_s_tready = !w_full;

    gr_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_s_tvalid),
        .i_push_data(w_req),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_empty    (w_empty),
        .o_head     (w_head)
    );

    gr_scan #(
        .SCALE_FACTOR(SCALE_FACTOR)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_head       (w_head),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_cell_x     (w_cell_x),
        .o_cell_y     (w_cell_y),
        .o_pixel_mask (w_mask),
        .o_pixel_color(w_color),
        .o_last_write (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_color, w_mask, w_cell_y, w_cell_x};

endmodule

// ===== hdl/gr_ram.sv =====
module gr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gr_fifo.sv =====
module gr_fifo
    import gr_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_push_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_req o_head
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FIFO_DEPTH - 1);

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [$bits(t_req)-1:0] w_rdata;
    logic w_push, w_pop;

    assign o_full  = (r_count == CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_ADDR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // an entry counted in r_count was written on an earlier edge, so the
    // registered read at r_rd_ptr never races its own write
    gr_ram #(
        .WIDTH($bits(t_req)),
        .DEPTH(FIFO_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_push),
        .i_waddr(r_wr_ptr),
        .i_wdata(i_push_data),
        .i_re   (w_pop),
        .i_raddr(r_rd_ptr),
        .o_rdata(w_rdata)
    );

    assign o_head = t_req'(w_rdata);

endmodule

// ===== hdl/gr_scan.sv =====
module gr_scan
    import gr_pkg::*;
#(
    parameter int SCALE_FACTOR = DEF_SCALE_FACTOR
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_empty,
    output logic        o_pop,
    input  t_req        i_head,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_cell_x,
    output logic [10:0] o_cell_y,
    output logic [8:0]  o_pixel_mask,
    output logic [15:0] o_pixel_color,
    output logic        o_last_write
);

    localparam logic [10:0] PITCH_BIG = 11'(SCALE_FACTOR);
    localparam logic [1:0]  SPAN_BIG  = 2'((SCALE_FACTOR > 3) ? 3 : SCALE_FACTOR);
    localparam logic [2:0]  COL_LAST  = 3'(GLYPH_COLS - 1);
    localparam logic [2:0]  ROW_LAST  = 3'(GLYPH_ROWS - 1);

    logic [10:0] r_width, r_height;

    // scan stage
    logic                   r_load;
    logic                   r_busy;
    logic [GLYPH_CELLS-1:0] r_bits;
    logic [2:0]             r_col, r_row;
    logic [10:0]            r_cx, r_cy, r_y0;
    logic [15:0]            r_color;
    logic                   r_big;

    // one-deep holding stage: a write waits here until it is known whether
    // another write of the same character follows
    logic        r_p_valid, r_p_final;
    logic [10:0] r_p_x, r_p_y;
    logic [8:0]  r_p_mask;
    logic [15:0] r_p_color;

    logic        r_o_valid, r_o_last;
    logic [10:0] r_o_x, r_o_y;
    logic [8:0]  r_o_mask;
    logic [15:0] r_o_color;

    logic [10:0] w_pitch;
    logic [1:0]  w_span;
    logic [2:0]  w_vis_x, w_vis_y;
    logic [8:0]  w_mask;
    logic        w_produce, w_out_free, w_step, w_final, w_drain;
    logic [12:0] w_px, w_py;

    always_comb begin
        w_pitch = r_big ? PITCH_BIG : 11'd1;
        w_span  = r_big ? SPAN_BIG : 2'd1;
        for (int d = 0; d < 3; d++) begin
            w_px = {{2{r_cx[10]}}, r_cx} + 13'(d);
            w_py = {{2{r_cy[10]}}, r_cy} + 13'(d);
            w_vis_x[d] = (2'(d) < w_span) && !w_px[12] && (w_px[11:0] < {1'b0, r_width});
            w_vis_y[d] = (2'(d) < w_span) && !w_py[12] && (w_py[11:0] < {1'b0, r_height});
        end
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                w_mask[dy*3+dx] = w_vis_x[dx] && w_vis_y[dy];
            end
        end
    end

    assign w_final    = (r_col == COL_LAST) && (r_row == ROW_LAST);
    assign w_produce  = r_busy && r_bits[0] && (w_mask != '0);
    assign w_out_free = !r_o_valid || i_ready;
    assign w_step     = r_busy && !(w_produce && r_p_valid && !w_out_free);
    assign w_drain    = r_p_valid && r_p_final && !(w_step && w_produce) && w_out_free;
    assign o_pop      = !i_empty && ((!r_busy && !r_load) || (w_step && w_final));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_SCREEN_WIDTH;
            r_height <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_load <= o_pop;
            if (r_load) begin
                r_busy <= 1'b1;
            end else if (w_step && w_final) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_bits  <= glyph_bits(i_head.char_code);
            r_col   <= '0;
            r_row   <= '0;
            r_cx    <= {i_head.pos_x[9], i_head.pos_x};
            r_cy    <= {i_head.pos_y[9], i_head.pos_y};
            r_y0    <= {i_head.pos_y[9], i_head.pos_y};
            r_color <= i_head.color;
            r_big   <= i_head.big_scale;
        end else if (w_step) begin
            r_bits <= r_bits >> 1;
            if (r_row == ROW_LAST) begin
                r_row <= '0;
                r_col <= r_col + 1'b1;
                r_cy  <= r_y0;
                r_cx  <= r_cx + w_pitch;
            end else begin
                r_row <= r_row + 1'b1;
                r_cy  <= r_cy + w_pitch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_final <= 1'b0;
        end else begin
            if (w_step && w_produce) begin
                r_p_valid <= 1'b1;
                r_p_final <= w_final;
            end else begin
                if (w_step && w_final && r_p_valid) begin
                    r_p_final <= 1'b1;
                end
                if (w_drain) begin
                    r_p_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_produce) begin
            r_p_x     <= r_cx;
            r_p_y     <= r_cy;
            r_p_mask  <= w_mask;
            r_p_color <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((w_step && w_produce && r_p_valid) || w_drain) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_step && w_produce && r_p_valid) || w_drain) begin
            r_o_x     <= r_p_x;
            r_o_y     <= r_p_y;
            r_o_mask  <= r_p_mask;
            r_o_color <= r_p_color;
            r_o_last  <= r_p_final;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_cell_x      = r_o_x;
    assign o_cell_y      = r_o_y;
    assign o_pixel_mask  = r_o_mask;
    assign o_pixel_color = r_o_color;
    assign o_last_write  = r_o_last;

endmodule

// ===== sim/glyph_rasterizer_tb.sv =====
`timescale 1ns / 1ps

module glyph_rasterizer_tb;
    import gr_pkg::*;

    localparam int SCALE        = DEF_SCALE_FACTOR;
    localparam int CYCLE_LIMIT  = 400000;
    // drain time for a full FIFO plus the glyph in flight
    localparam int DRAIN_CYCLES = (DEF_FIFO_DEPTH + 2) * 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int REPORT_MAX   = 10;

    // column bytes of the 95 printable glyphs, column 0 in the top byte
    localparam logic [39:0] GLYPH_FONT [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
        40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    typedef struct packed {
        logic [10:0] cell_x;
        logic [10:0] cell_y;
        logic [8:0]  mask;
        logic [15:0] color;
        logic        last;
    } t_pixel_write;

    class glyph_scoreboard;
        int unsigned  width;
        int unsigned  height;
        t_pixel_write expected_writes[$];
        int unsigned  mismatches;
        int unsigned  writes_checked;

        function new();
            width          = RST_SCREEN_WIDTH;
            height         = RST_SCREEN_HEIGHT;
            mismatches     = 0;
            writes_checked = 0;
        endfunction

        function bit on_screen(int px, int py);
            return px >= 0 && py >= 0 && px < int'(width) && py < int'(height);
        endfunction

        // expand one character request into its pixel-block writes
        function void note_request(t_req r);
            t_pixel_write glyph_writes[$];
            t_pixel_write w;
            logic [39:0]  cols;
            logic [7:0]   code;
            int           x0, y0, pitch, span, cx, cy;
            logic [8:0]   mask;
            x0    = $signed(r.pos_x);
            y0    = $signed(r.pos_y);
            code  = r.char_code;
            pitch = r.big_scale ? SCALE : 1;
            span  = (pitch > 3) ? 3 : pitch;
            if (code < FIRST_CODE || code > LAST_CODE) begin
                code = FIRST_CODE;
            end
            cols = GLYPH_FONT[code - FIRST_CODE];
            for (int c = 0; c < 5; c++) begin
                for (int row = 0; row < 7; row++) begin
                    if (cols[(4 - c) * 8 + row]) begin
                        cx   = x0 + c * pitch;
                        cy   = y0 + row * pitch;
                        mask = '0;
                        for (int dy = 0; dy < span; dy++) begin
                            for (int dx = 0; dx < span; dx++) begin
                                if (on_screen(cx + dx, cy + dy)) begin
                                    mask[dy * 3 + dx] = 1'b1;
                                end
                            end
                        end
                        if (mask != '0) begin
                            w.cell_x = cx[10:0];
                            w.cell_y = cy[10:0];
                            w.mask   = mask;
                            w.color  = r.color;
                            w.last   = 1'b0;
                            glyph_writes.push_back(w);
                        end
                    end
                end
            end
            if (glyph_writes.size() > 0) begin
                glyph_writes[glyph_writes.size() - 1].last = 1'b1;
            end
            foreach (glyph_writes[i]) begin
                expected_writes.push_back(glyph_writes[i]);
            end
        endfunction

        function void check_write(logic [47:0] d, logic last);
            t_pixel_write got, want;
            got.cell_x = d[10:0];
            got.cell_y = d[21:11];
            got.mask   = d[30:22];
            got.color  = d[46:31];
            got.last   = last;
            writes_checked++;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected write: x=%0d y=%0d mask=%03h color=%04h last=%0b",
                             $signed(got.cell_x), $signed(got.cell_y), got.mask,
                             got.color, got.last);
                end
                return;
            end
            want = expected_writes.pop_front();
            if (got.cell_x != want.cell_x || got.cell_y != want.cell_y ||
                    got.mask != want.mask || got.color != want.color ||
                    got.last != want.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("write mismatch: exp x=%0d y=%0d mask=%03h color=%04h last=%0b",
                             $signed(want.cell_x), $signed(want.cell_y), want.mask,
                             want.color, want.last);
                    $display("                got x=%0d y=%0d mask=%03h color=%04h last=%0b",
                             $signed(got.cell_x), $signed(got.cell_y), got.mask,
                             got.color, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [10:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;

    glyph_scoreboard sb;
    int unsigned     cycles;
    int unsigned     requests_sent;
    int unsigned     screen_sizes;
    int              hold_token;
    int              hold_seen;
    int              hold_left;
    int              stall_mode;
    int              stall_left;

    glyph_rasterizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes outstanding", cycles, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_write(o_m_tdata, o_m_tlast);
        end
    end

    // output stall: hold when asked, else runs of always, mostly or rarely ready
    always @(negedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(5, 60);
            end
            stall_left--;
            case (stall_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic t_req make_req(int x, int y, int code, int color, bit big);
        t_req r;
        r.pos_x     = x[9:0];
        r.pos_y     = y[9:0];
        r.char_code = code[7:0];
        r.color     = color[15:0];
        r.big_scale = big;
        return r;
    endfunction

    // mostly near the visible area, sometimes anywhere in the signed range
    function automatic t_req random_req();
        int x_hi, y_hi, x, y, code;
        x_hi = (sb.width > 505) ? 511 : int'(sb.width) + 6;
        y_hi = (sb.height > 505) ? 511 : int'(sb.height) + 6;
        if ($urandom_range(0, 4) == 0) begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
        end else begin
            x = int'($urandom_range(0, x_hi + 20)) - 20;
            y = int'($urandom_range(0, y_hi + 20)) - 20;
        end
        if ($urandom_range(0, 6) == 0) begin
            code = $urandom_range(0, 255);
        end else begin
            code = $urandom_range(FIRST_CODE, LAST_CODE);
        end
        return make_req(x, y, code, $urandom_range(0, 65535), $urandom_range(0, 1));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input t_req r);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, r[43:0]};
        i_s_tuser  <= r.big_scale;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(r);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_screen(input int w, input int h);
        wait_drained();
        // blank or clipped glyphs may still be in the scanner
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_SCREEN_WIDTH;
        i_cfg_wdata <= w[10:0];
        @(negedge i_clk);
        i_cfg_idx   <= CFG_SCREEN_HEIGHT;
        i_cfg_wdata <= h[10:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.width  = w & 32'h7FF;
        sb.height = h & 32'h7FF;
        screen_sizes++;
    endtask

    task automatic random_bursts(input int n);
        int left, blen;
        left = n;
        while (left > 0) begin
            blen = $urandom_range(1, 6);
            for (int i = 0; i < blen && left > 0; i++) begin
                send_request(random_req());
                left--;
            end
            case ($urandom_range(0, 9))
                0:       wait_drained();
                1, 2:    ;
                default: idle_for($urandom_range(1, 12));
            endcase
        end
    endtask

    initial begin
        t_req directed[$];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SCREEN_WIDTH;
        i_cfg_wdata   = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        i_m_tready    = 1'b0;
        cycles        = 0;
        requests_sent = 0;
        screen_sizes  = 1;
        hold_token    = 0;
        hold_seen     = 0;
        hold_left     = 0;
        stall_mode    = 0;
        stall_left    = 0;
        sb            = new();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default 160 x 128 screen
        directed.push_back(make_req(0, 0, "A", 16'h0000, 1'b0));
        directed.push_back(make_req(0, 0, "A", 16'hFFFF, 1'b1));
        directed.push_back(make_req(20, 20, 8'h20, 16'h1234, 1'b1));
        directed.push_back(make_req(10, 10, 8'h21, 16'h5A5A, 1'b0));
        directed.push_back(make_req(10, 10, 8'h7E, 16'hA5A5, 1'b1));
        directed.push_back(make_req(10, 10, 8'h00, 16'hFFFF, 1'b1));
        directed.push_back(make_req(10, 10, 8'h1F, 16'h0001, 1'b0));
        directed.push_back(make_req(10, 10, 8'h7F, 16'h8000, 1'b1));
        directed.push_back(make_req(10, 10, 8'hFF, 16'h7FFF, 1'b0));
        directed.push_back(make_req(-512, -512, "#", 16'hFFFF, 1'b1));
        directed.push_back(make_req(511, 511, "#", 16'h0000, 1'b0));
        directed.push_back(make_req(-512, 511, "#", 16'h0F0F, 1'b1));
        directed.push_back(make_req(-1, -1, "#", 16'hF0F0, 1'b1));
        directed.push_back(make_req(-2, -2, "@", 16'hC3C3, 1'b1));
        directed.push_back(make_req(-3, 4, "8", 16'h3C3C, 1'b0));
        directed.push_back(make_req(157, 124, "M", 16'h1111, 1'b0));
        directed.push_back(make_req(150, 115, "W", 16'h2222, 1'b1));
        directed.push_back(make_req(158, 126, "B", 16'h4444, 1'b1));
        directed.push_back(make_req(144, 107, 8'h7F, 16'h8888, 1'b1));
        directed.push_back(make_req(100, 50, "g", 16'hBEEF, 1'b1));
        foreach (directed[i]) begin
            send_request(directed[i]);
        end
        wait_drained();

        // output held off while requests keep coming, so the input side backs up
        hold_token++;
        for (int i = 0; i < 12; i++) begin
            send_request(random_req());
        end
        random_bursts(10);

        set_screen(1, 1);
        random_bursts(10);
        set_screen(0, 50);
        random_bursts(5);
        set_screen(2047, 0);
        random_bursts(5);
        set_screen(2047, 2047);
        random_bursts(15);
        set_screen(1024, 1024);
        random_bursts(15);
        set_screen($urandom_range(1, 1024), $urandom_range(1, 1024));
        random_bursts(20);
        set_screen($urandom_range(1, 64), $urandom_range(1, 64));
        random_bursts(15);
        set_screen(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT);
        random_bursts(15);

        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d character requests, checked %0d pixel-block writes", requests_sent,
                 sb.writes_checked);
        $display("over %0d screen sizes incl. zero, one-pixel and full-range clipping",
                 screen_sizes);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d writes never seen", sb.mismatches, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
